// File: src/cnws_pkg.sv
// cnws_pkg: shared types and constants of the crank-nicolson wave stepper
// no dependencies
`timescale 1ns / 1ps

package cnws_pkg;

	localparam int GRID_POINTS = 64;
	localparam int ADDR_W = $clog2(GRID_POINTS);
	localparam int SAMP_W = 18;
	localparam int CPL_W = 24;
	localparam int STEP_W = 16;
	localparam int SWEEP_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic signed [SAMP_W-1:0] SAT_HI = 18'sh1FFFF;
	localparam logic signed [SAMP_W-1:0] SAT_LO = -18'sh20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUPLING   = 3'd0,
		REG_RECIP_RE   = 3'd1,
		REG_RECIP_IM   = 3'd2,
		REG_TIME_STEPS = 3'd3,
		REG_SWEEPS     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RHS,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	// per-point operation phases
	typedef enum logic [2:0] {
		PH_RD0,
		PH_RD1,
		PH_MUL,
		PH_NUM,
		PH_REC,
		PH_WR
	} phase_t;

	// saturate a wide signed value to 18 bits
	function automatic logic signed [SAMP_W-1:0] sat18(input logic signed [47:0] v);
		logic signed [SAMP_W-1:0] r;
		if (v > 48'sd131071) r = SAT_HI;
		else if (v < -48'sd131072) r = SAT_LO;
		else r = v[SAMP_W-1:0];
		return r;
	endfunction

endpackage

// File: src/crank_nicolson_wave_step.sv
// crank_nicolson_wave_step: loads a complex wavefunction, steps it, streams it back
// depends on cnws_pkg
`timescale 1ns / 1ps

// usage
//   s_axis carries one grid sample per request (tdata = sample_re, sample_im).
//   the first GRID_POINTS-1 requests only load the wave memory; the last one
//   starts time_steps crank-nicolson steps, each one rhs pass and sweeps
//   gauss-seidel passes over the grid.
//   per point, the rhs pass steps through read, multiply, numerator and write,
//   a sweep pass through read, multiply, numerator, reciprocal product and
//   write, in a shared sequencer around the wave and rhs memories (single
//   write port each), plus one priming read per pass.
//   no new sample is accepted while a run or its output is in progress.
//   m_axis then emits GRID_POINTS results in index order, tlast on the final
//   one; a one-entry output register holds a result while the receiver stalls,
//   and the memory read ahead waits for it.
//   reset (arst_n low) clears the load count, counters and the registers to
//   coupling 1.0, recip 1.0+0i, one step, 200 sweeps; memory contents are not
//   cleared, every entry is loaded before its value is used. the user must write
//   configuration via cfg_we/cfg_index/cfg_data only while idle; not enforced.
module crank_nicolson_wave_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [17:0] sample_re, [35:18] sample_im
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [17:0] out_re, [35:18] out_im
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [cnws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cnws_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = cnws_pkg::ADDR_W;
	localparam int SW = cnws_pkg::SAMP_W;
	localparam logic [AW:0] NPTS = (AW+1)'(cnws_pkg::GRID_POINTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(cnws_pkg::GRID_POINTS - 1);

	// configuration registers
	logic [cnws_pkg::CPL_W-1:0]   coupling_q;
	logic signed [SW-1:0]         recip_re_q, recip_im_q;
	logic [cnws_pkg::STEP_W-1:0]  time_steps_q;
	logic [cnws_pkg::SWEEP_W-1:0] sweeps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q   <= 24'd65536;
			recip_re_q   <= 18'sd16384;
			recip_im_q   <= '0;
			time_steps_q <= 16'd1;
			sweeps_q     <= 8'd200;
		end else if (cfg_we) begin
			case (cnws_pkg::cfg_reg_t'(cfg_index))
				cnws_pkg::REG_COUPLING:   coupling_q <= cfg_data;
				cnws_pkg::REG_RECIP_RE:   recip_re_q <= cfg_data[SW-1:0];
				cnws_pkg::REG_RECIP_IM:   recip_im_q <= cfg_data[SW-1:0];
				cnws_pkg::REG_TIME_STEPS: time_steps_q <= cfg_data[15:0];
				cnws_pkg::REG_SWEEPS:     sweeps_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// memories: {im, re}, one write and one registered read port each
	logic [2*SW-1:0] wave_mem [cnws_pkg::GRID_POINTS];
	logic [2*SW-1:0] rhs_mem  [cnws_pkg::GRID_POINTS];
	logic            wave_we, rhs_we;
	logic [AW-1:0]   wave_waddr, wave_raddr, rhs_addr;
	logic [2*SW-1:0] wave_wdata, rhs_wdata, wave_rd_q, rhs_rd_q;

	always_ff @(posedge clk) begin
		if (wave_we) wave_mem[wave_waddr] <= wave_wdata;
		wave_rd_q <= wave_mem[wave_raddr];
	end
	always_ff @(posedge clk) begin
		if (rhs_we) rhs_mem[rhs_addr] <= rhs_wdata;
		rhs_rd_q <= rhs_mem[rhs_addr];
	end

	// control
	cnws_pkg::state_t state_q, state_d;
	cnws_pkg::phase_t ph_q;
	logic [AW:0]      load_cnt_q;
	logic [AW-1:0]    pt_q;
	logic [cnws_pkg::STEP_W-1:0]  step_q;
	logic [cnws_pkg::SWEEP_W-1:0] sweep_q;
	logic             pass_done, run_start;

	// per-point working registers; the current point and its right
	// neighbour are held as a window so only the new right point is read
	logic signed [SW-1:0] cur_re_q, cur_im_q, lft_re_q, lft_im_q, rgt_re_q, rgt_im_q;
	logic signed [SW-1:0] rhs_re_q, rhs_im_q, t_re_q, t_im_q;
	logic signed [42:0]   pr_q, pi_q;
	logic signed [35:0]   m0_q, m1_q, m2_q, m3_q;

	// emit path
	logic       rd_pend_q;
	logic [AW:0] emit_cnt_q;
	logic       out_v_q, out_l_q;
	logic [2*SW-1:0] out_d_q;

	assign s_axis_tready = (state_q == cnws_pkg::ST_LOAD);
	assign run_start = s_axis_tvalid && s_axis_tready && (load_cnt_q == NPTS - 1'b1);
	assign pass_done = (ph_q == cnws_pkg::PH_WR) && (pt_q == LAST_IDX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cnws_pkg::ST_LOAD:
				if (run_start) state_d = (time_steps_q == '0) ? cnws_pkg::ST_EMIT
				                                              : cnws_pkg::ST_RHS;
			cnws_pkg::ST_RHS:
				if (pass_done) state_d = (sweeps_q == '0) ?
					((step_q + 1'b1 == time_steps_q) ? cnws_pkg::ST_EMIT : cnws_pkg::ST_RHS)
					: cnws_pkg::ST_SWEEP;
			cnws_pkg::ST_SWEEP:
				if (pass_done && (sweep_q + 1'b1 == sweeps_q))
					state_d = (step_q + 1'b1 == time_steps_q) ? cnws_pkg::ST_EMIT
					                                          : cnws_pkg::ST_RHS;
			cnws_pkg::ST_EMIT:
				if (emit_cnt_q == NPTS && !rd_pend_q && m_axis_tvalid && m_axis_tready
				    && m_axis_tlast) state_d = cnws_pkg::ST_LOAD;
			default: state_d = cnws_pkg::ST_LOAD;
		endcase
	end

	// coupling products rounded to q3.14 (tie up)
	function automatic logic signed [42:0] cmul(input logic [23:0] c,
	                                            input logic signed [19:0] v);
		logic signed [45:0] p;
		p = 46'($signed({1'b0, c})) * 46'(v) + 46'sd32768;
		return 43'(p >>> 16);
	endfunction

	logic signed [19:0] dr, di, sr, si;
	logic signed [SW-1:0] nbr_re, nbr_im;
	always_comb begin
		// neighbours, zero at the borders
		dr = 20'(2 * cur_re_q) - 20'(lft_re_q) - 20'(nbr_re);
		di = 20'(2 * cur_im_q) - 20'(lft_im_q) - 20'(nbr_im);
		sr = 20'(lft_re_q) + 20'(nbr_re);
		si = 20'(lft_im_q) + 20'(nbr_im);
	end
	assign nbr_re = (pt_q == LAST_IDX) ? '0 : rgt_re_q;
	assign nbr_im = (pt_q == LAST_IDX) ? '0 : rgt_im_q;

	logic signed [47:0] rec_re_w, rec_im_w;
	assign rec_re_w = (48'(m0_q) - 48'(m1_q) + 48'sd8192) >>> 14;
	assign rec_im_w = (48'(m2_q) + 48'(m3_q) + 48'sd8192) >>> 14;

	always_comb begin
		wave_we = 1'b0;
		wave_waddr = pt_q;
		wave_wdata = {rgt_im_q, rgt_re_q};
		rhs_we = 1'b0;
		rhs_wdata = {cnws_pkg::sat18(48'(cur_im_q) + 48'(pr_q)),
		             cnws_pkg::sat18(48'(cur_re_q) - 48'(pi_q))};
		rhs_addr = pt_q;
		wave_raddr = pt_q + 1'b1;
		if (state_q == cnws_pkg::ST_LOAD) begin
			wave_we = s_axis_tvalid;
			wave_waddr = load_cnt_q[AW-1:0];
			wave_wdata = {s_axis_tdata[35:18], s_axis_tdata[17:0]};
			wave_raddr = '0;
		end else if (state_q == cnws_pkg::ST_EMIT) begin
			wave_raddr = emit_cnt_q[AW-1:0];
		end else if (ph_q == cnws_pkg::PH_RD0) begin
			wave_raddr = '0;
		end else if (ph_q == cnws_pkg::PH_WR) begin
			if (state_q == cnws_pkg::ST_RHS) rhs_we = 1'b1;
			else begin
				wave_we = 1'b1;
				wave_wdata = {cnws_pkg::sat18(rec_im_w), cnws_pkg::sat18(rec_re_w)};
			end
		end
	end

	// sequencer: PH_RD0 only at point 0 primes the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnws_pkg::ST_LOAD;
			ph_q <= cnws_pkg::PH_RD0;
			load_cnt_q <= '0;
			pt_q <= '0;
			step_q <= '0;
			sweep_q <= '0;
			rd_pend_q <= 1'b0;
			emit_cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_axis_tvalid && s_axis_tready)
				load_cnt_q <= run_start ? '0 : load_cnt_q + 1'b1;
			if (state_q == cnws_pkg::ST_RHS || state_q == cnws_pkg::ST_SWEEP) begin
				case (ph_q)
					cnws_pkg::PH_RD0: ph_q <= cnws_pkg::PH_RD1;
					cnws_pkg::PH_RD1: ph_q <= cnws_pkg::PH_MUL;
					cnws_pkg::PH_MUL: ph_q <= cnws_pkg::PH_NUM;
					cnws_pkg::PH_NUM: ph_q <= (state_q == cnws_pkg::ST_RHS) ?
					                          cnws_pkg::PH_WR : cnws_pkg::PH_REC;
					cnws_pkg::PH_REC: ph_q <= cnws_pkg::PH_WR;
					cnws_pkg::PH_WR: begin
						if (pt_q == LAST_IDX) begin
							pt_q <= '0;
							ph_q <= cnws_pkg::PH_RD0;
							if (state_q == cnws_pkg::ST_SWEEP) begin
								if (sweep_q + 1'b1 == sweeps_q) begin
									sweep_q <= '0;
									step_q <= step_q + 1'b1;
								end else sweep_q <= sweep_q + 1'b1;
							end else if (sweeps_q == '0) step_q <= step_q + 1'b1;
						end else begin
							pt_q <= pt_q + 1'b1;
							ph_q <= cnws_pkg::PH_RD1;
						end
					end
					default: ph_q <= cnws_pkg::PH_RD0;
				endcase
			end
			if (state_q == cnws_pkg::ST_EMIT) begin
				if (rd_pend_q) rd_pend_q <= 1'b0;
				if (rd_pend_q) begin
					out_v_q <= 1'b1;
				end else if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
				if (!rd_pend_q && emit_cnt_q != NPTS &&
				    (!out_v_q || m_axis_tready)) begin
					rd_pend_q <= 1'b1;
					emit_cnt_q <= emit_cnt_q + 1'b1;
				end
				if (state_d == cnws_pkg::ST_LOAD) begin
					emit_cnt_q <= '0;
					step_q <= '0;
				end
			end
		end
	end

	// datapath (no reset)
	always_ff @(posedge clk) begin
		if (state_q == cnws_pkg::ST_RHS || state_q == cnws_pkg::ST_SWEEP) begin
			case (ph_q)
				cnws_pkg::PH_RD0: begin
					lft_re_q <= '0;
					lft_im_q <= '0;
				end
				cnws_pkg::PH_RD1: begin
					if (pt_q == '0) begin
						cur_re_q <= wave_rd_q[SW-1:0];
						cur_im_q <= wave_rd_q[2*SW-1:SW];
					end
				end
				cnws_pkg::PH_MUL: begin
					rgt_re_q <= wave_rd_q[SW-1:0];
					rgt_im_q <= wave_rd_q[2*SW-1:SW];
					rhs_re_q <= rhs_rd_q[SW-1:0];
					rhs_im_q <= rhs_rd_q[2*SW-1:SW];
				end
				cnws_pkg::PH_NUM: begin
					if (state_q == cnws_pkg::ST_RHS) begin
						pr_q <= cmul(coupling_q, dr);
						pi_q <= cmul(coupling_q, di);
					end else begin
						t_re_q <= cnws_pkg::sat18(48'(rhs_re_q) + 48'(cmul(coupling_q, si)));
						t_im_q <= cnws_pkg::sat18(48'(rhs_im_q) - 48'(cmul(coupling_q, sr)));
					end
				end
				cnws_pkg::PH_REC: ;
				cnws_pkg::PH_WR: begin
					// slide the window; the right point is the next current
					if (state_q == cnws_pkg::ST_SWEEP) begin
						lft_re_q <= cnws_pkg::sat18(rec_re_w);
						lft_im_q <= cnws_pkg::sat18(rec_im_w);
					end else begin
						lft_re_q <= cur_re_q;
						lft_im_q <= cur_im_q;
					end
					cur_re_q <= rgt_re_q;
					cur_im_q <= rgt_im_q;
				end
				default: ;
			endcase
		end
		if (state_q == cnws_pkg::ST_SWEEP && ph_q == cnws_pkg::PH_REC) begin
			m0_q <= 36'(t_re_q) * 36'(recip_re_q);
			m1_q <= 36'(t_im_q) * 36'(recip_im_q);
			m2_q <= 36'(t_re_q) * 36'(recip_im_q);
			m3_q <= 36'(t_im_q) * 36'(recip_re_q);
		end
		if (state_q == cnws_pkg::ST_EMIT && rd_pend_q) begin
			out_d_q <= wave_rd_q;
			out_l_q <= (emit_cnt_q == NPTS);
		end
	end

	// the write phase of the rhs pass stores the rhs, the sweep stores psi;
	// the product m* is registered in PH_REC and used in PH_WR
	assign m_axis_tvalid = out_v_q && !rd_pend_q;
	assign m_axis_tdata = {4'd0, out_d_q};
	assign m_axis_tlast = out_l_q;

	// assertions
	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cnws_pkg::ST_LOAD) |-> !s_axis_tready)
		else $error("input accepted during run");
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (state_q == cnws_pkg::ST_EMIT))
		else $error("output outside emit");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q < NPTS)
		else $error("load count overflow");

endmodule

// File: verif/tb_crank_nicolson_wave_step.sv
// tb_crank_nicolson_wave_step: self-checking bench for the crank-nicolson wave stepper
// loads whole grids, predicts every evolved sample and compares it on the output stream
// depends on cnws_pkg and crank_nicolson_wave_step
`timescale 1ns / 1ps

module tb_crank_nicolson_wave_step;

	localparam int SAMP_W = cnws_pkg::SAMP_W;
	localparam int GRID_POINTS = cnws_pkg::GRID_POINTS;
	localparam int CFG_IDX_W = cnws_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = cnws_pkg::CFG_DATA_W;
	localparam int STEP_W = cnws_pkg::STEP_W;
	localparam int SWEEP_W = cnws_pkg::SWEEP_W;

	localparam int N_DIRECTED = 25;
	localparam int N_TAIL = 4;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	crank_nicolson_wave_step u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one evolved sample as it should leave the block
	typedef struct {
		logic signed [SAMP_W-1:0] re;
		logic signed [SAMP_W-1:0] im;
		logic                     last;
	} sample_t;

	// directed grid rows; with the identity setting a sample comes back unchanged
	typedef struct {
		logic signed [SAMP_W-1:0] re;
		logic signed [SAMP_W-1:0] im;
		bit                       known;
	} grid_row_t;

	sample_t evolved_q[$];
	int fails = 0;
	int results_seen = 0;
	int grids_done = 0;
	bit long_hold_req = 1'b0;
	bit stim_done = 1'b0;

	// predictor copy of the registers
	longint cpl_q16 = 65536;
	longint rcp_re = 16384;
	longint rcp_im = 0;
	int n_steps = 1;
	int n_sweeps = 200;

	// predictor copy of the grid
	longint psi_re[GRID_POINTS], psi_im[GRID_POINTS];
	longint b_re[GRID_POINTS], b_im[GRID_POINTS];
	int n_loaded = 0;
	grid_row_t typed_row[GRID_POINTS];

	function automatic longint clamp18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	// round to nearest, ties toward +inf
	function automatic longint round_shr(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint couple(longint v);
		return round_shr(cpl_q16 * v, 16);
	endfunction

	function automatic longint psi_re_at(int i);
		return (i < 0 || i >= GRID_POINTS) ? 0 : psi_re[i];
	endfunction

	function automatic longint psi_im_at(int i);
		return (i < 0 || i >= GRID_POINTS) ? 0 : psi_im[i];
	endfunction

	// advance the loaded grid by n_steps steps and queue the emitted samples
	task automatic evolve_grid();
		longint dr, di, sr, si, tr, ti;
		sample_t s;
		for (int st = 0; st < n_steps; st++) begin
			// rhs = B * psi
			for (int i = 0; i < GRID_POINTS; i++) begin
				dr = 2 * psi_re[i] - psi_re_at(i - 1) - psi_re_at(i + 1);
				di = 2 * psi_im[i] - psi_im_at(i - 1) - psi_im_at(i + 1);
				b_re[i] = clamp18(psi_re[i] - couple(di));
				b_im[i] = clamp18(psi_im[i] + couple(dr));
			end
			// in-place gauss-seidel, increasing index
			for (int sw = 0; sw < n_sweeps; sw++) begin
				for (int i = 0; i < GRID_POINTS; i++) begin
					sr = psi_re_at(i - 1) + psi_re_at(i + 1);
					si = psi_im_at(i - 1) + psi_im_at(i + 1);
					tr = clamp18(b_re[i] + couple(si));
					ti = clamp18(b_im[i] - couple(sr));
					psi_re[i] = clamp18(round_shr(tr * rcp_re - ti * rcp_im, 14));
					psi_im[i] = clamp18(round_shr(tr * rcp_im + ti * rcp_re, 14));
				end
			end
		end
		for (int i = 0; i < GRID_POINTS; i++) begin
			if (typed_row[i].known) begin
				s.re = typed_row[i].re;
				s.im = typed_row[i].im;
				typed_row[i].known = 1'b0;
			end else begin
				s.re = psi_re[i][SAMP_W-1:0];
				s.im = psi_im[i][SAMP_W-1:0];
			end
			s.last = (i == GRID_POINTS - 1);
			evolved_q.insert(evolved_q.size(), s);
		end
	endtask

	// one register write; caller lowers cfg_we after the last one
	task automatic write_reg(cnws_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			cnws_pkg::REG_COUPLING:   cpl_q16 = longint'(val);
			cnws_pkg::REG_RECIP_RE:   rcp_re = longint'($signed(val[SAMP_W-1:0]));
			cnws_pkg::REG_RECIP_IM:   rcp_im = longint'($signed(val[SAMP_W-1:0]));
			cnws_pkg::REG_TIME_STEPS: n_steps = int'(val[STEP_W-1:0]);
			cnws_pkg::REG_SWEEPS:     n_sweeps = int'(val[SWEEP_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] cpl, logic [CFG_DATA_W-1:0] rre,
			logic [CFG_DATA_W-1:0] rim, logic [CFG_DATA_W-1:0] steps,
			logic [CFG_DATA_W-1:0] sweeps);
		write_reg(cnws_pkg::REG_COUPLING, cpl);
		write_reg(cnws_pkg::REG_RECIP_RE, rre);
		write_reg(cnws_pkg::REG_RECIP_IM, rim);
		write_reg(cnws_pkg::REG_TIME_STEPS, steps);
		write_reg(cnws_pkg::REG_SWEEPS, sweeps);
		cfg_we <= 1'b0;
	endtask

	// offer one sample after a random gap; returns once it is accepted
	task automatic send_sample(logic signed [SAMP_W-1:0] re, logic signed [SAMP_W-1:0] im);
		int gap;
		gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, im, re};
		do @(posedge clk); while (!s_axis_tready);
		psi_re[n_loaded] = longint'(re);
		psi_im[n_loaded] = longint'(im);
		n_loaded++;
		if (n_loaded == GRID_POINTS) begin
			evolve_grid();
			n_loaded = 0;
		end
	endtask

	task automatic send_random_grid(int first);
		for (int i = first; i < GRID_POINTS; i++)
			send_sample(SAMP_W'($urandom), SAMP_W'($urandom));
	endtask

	// all requests answered, then a short settle before touching registers
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (evolved_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	grid_row_t dir_rows[N_DIRECTED];

	initial begin
		dir_rows = '{
			'{18'sd0, 18'sd0, 1}, '{18'sd131071, 18'sd131071, 1},
			'{-18'sd131072, -18'sd131072, 1}, '{18'sd131071, -18'sd131072, 1},
			'{-18'sd131072, 18'sd131071, 1}, '{18'sd1, -18'sd1, 1},
			'{-18'sd1, 18'sd1, 1}, '{18'sd87381, -18'sd87382, 1},
			'{-18'sd87382, 18'sd87381, 1}, '{18'sd16384, 18'sd0, 1},
			'{18'sd0, 18'sd16384, 1}, '{-18'sd16384, 18'sd0, 1},
			'{18'sd0, -18'sd16384, 1}, '{18'sd65536, 18'sd65535, 1},
			'{-18'sd65536, -18'sd65537, 1}, '{18'sd1, 18'sd0, 1},
			'{18'sd0, 18'sd1, 1}, '{-18'sd131071, 18'sd2, 1},
			'{18'sd8191, -18'sd8192, 1}, '{18'sd131070, 18'sd131070, 1},
			'{18'sd3, -18'sd3, 1}, '{18'sd21845, 18'sd43690, 1},
			'{-18'sd21846, -18'sd43691, 1}, '{18'sd255, 18'sd256, 1},
			'{18'sd131071, 18'sd0, 1}
		};
		foreach (typed_row[i]) typed_row[i].known = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity setting: no coupling, reciprocal 1.0, one step, one sweep
		set_config(24'd0, 24'd16384, 24'd0, 24'd1, 24'd1);
		for (int i = 0; i < N_DIRECTED; i++) begin
			typed_row[i] = dir_rows[i];
			send_sample(dir_rows[i].re, dir_rows[i].im);
		end
		send_random_grid(N_DIRECTED);
		wait_idle();

		// extremes: full coupling, most negative / most positive reciprocal, max sweeps
		set_config(24'hFFFFFF, 24'h020000, 24'h01FFFF, 24'd1, 24'd255);
		long_hold_req = 1'b1;
		send_random_grid(0);
		// a few samples of a further grid are offered while the receiver holds off
		for (int i = 0; i < N_TAIL; i++)
			send_sample(SAMP_W'($urandom), SAMP_W'($urandom));
		wait_idle();
		stim_done = 1'b1;
	end

	// receiver: random back-pressure, one long hold when asked
	initial begin
		int stall;
		sample_t want;
		logic signed [SAMP_W-1:0] got_re, got_im;
		forever begin
			if (long_hold_req) begin
				stall = LONG_HOLD;
			end else begin
				stall = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 19);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				if (long_hold_req) wait (m_axis_tvalid);
				long_hold_req = 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			results_seen++;
			got_re = m_axis_tdata[17:0];
			got_im = m_axis_tdata[35:18];
			if (evolved_q.size() == 0) begin
				$error("unexpected result re=%0d im=%0d", got_re, got_im);
				fails++;
			end else begin
				want = evolved_q.pop_front();
				if (got_re !== want.re) begin
					$error("out_re expected %0d got %0d", want.re, got_re);
					fails++;
				end
				if (got_im !== want.im) begin
					$error("out_im expected %0d got %0d", want.im, got_im);
					fails++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last expected %0d got %0d", want.last, m_axis_tlast);
					fails++;
				end
				if (want.last) grids_done++;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		repeat (100) @(posedge clk);
		if (evolved_q.size() != 0) begin
			$error("%0d expected results never arrived", evolved_q.size());
			fails++;
		end
		$display("run covered %0d grids and %0d samples over identity and extreme settings",
			grids_done, results_seen);
		$display("one long receiver hold stalled the input while further samples waited");
		if (fails == 0) begin
			$display("PASS crank_nicolson_wave_step");
		end else begin
			$display("FAIL crank_nicolson_wave_step");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("FAIL crank_nicolson_wave_step");
		$finish;
	end

endmodule

// File: files.f
src/cnws_pkg.sv
src/crank_nicolson_wave_step.sv
verif/tb_crank_nicolson_wave_step.sv
